FILE: rtl/vtyp_pkg.sv
// Shared constants, types and helpers for the vector-to-yaw/pitch direction finder.
// No dependencies; imported by every module of the block.
package vtyp_pkg;

   localparam int COORD_BITS_DEF    = 24;
   localparam int CORDIC_STAGES_DEF = 16;

   // Datapath widths of the rotation engine and of the angle accumulator.
   localparam int DATA_W  = 64;
   localparam int ANG_W   = 32;
   localparam int YAW_W   = 15;
   localparam int PITCH_W = 14;
   localparam int OUT_YAW_W = 17;
   localparam int OFS_W   = 16;
   localparam int GAIN_W  = 30;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_X   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_Y   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_Z   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_OFFSET = 2'd3;

   localparam logic [31:0] RST_TARGET_X   = 32'd14080;
   localparam logic [31:0] RST_TARGET_Y   = 32'd17152;
   localparam logic [31:0] RST_TARGET_Z   = 32'd2560;
   localparam logic [OFS_W-1:0] RST_YAW_OFFSET = 16'd5760;

   localparam logic signed [ANG_W-1:0] DEG90       = 32'sd1474560;
   localparam logic [GAIN_W-1:0]       INV_GAIN    = 30'd652032874;
   localparam logic signed [ANG_W-1:0] YAW_LIMIT   = 32'sd11520;
   localparam logic signed [ANG_W-1:0] PITCH_LIMIT = 32'sd5760;

   typedef struct packed {
      logic horiz_zero;
      logic coincident;
   } flags_type;

   // atan(2^-i) in 1/16384 degree, rounded.
   function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         0:       v = 32'sd737280;
         1:       v = 32'sd435242;
         2:       v = 32'sd229970;
         3:       v = 32'sd116736;
         4:       v = 32'sd58595;
         5:       v = 32'sd29326;
         6:       v = 32'sd14667;
         7:       v = 32'sd7334;
         8:       v = 32'sd3667;
         9:       v = 32'sd1833;
         10:      v = 32'sd917;
         11:      v = 32'sd458;
         12:      v = 32'sd229;
         13:      v = 32'sd115;
         14:      v = 32'sd57;
         15:      v = 32'sd29;
         16:      v = 32'sd14;
         17:      v = 32'sd7;
         18:      v = 32'sd4;
         19:      v = 32'sd2;
         20:      v = 32'sd1;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

   // Round half up to 1/64 degree, then clamp to +-lim.
   function automatic logic signed [ANG_W-1:0] finish_angle(
      input logic signed [ANG_W-1:0] z,
      input logic signed [ANG_W-1:0] lim
   );
      logic signed [ANG_W-1:0] r;
      r = (z + 32'sd128) >>> 8;
      if (r > lim) begin
         r = lim;
      end else if (r < -lim) begin
         r = -lim;
      end
      return r;
   endfunction

endpackage

FILE: rtl/vtyp_stage.sv
// One registered CORDIC vectoring micro-rotation with a sideband payload.
// Depends on vtyp_pkg.
module vtyp_stage #(
   parameter int IDX    = 0,
   parameter int SIDE_W = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  logic signed [vtyp_pkg::DATA_W-1:0] x_in,
   input  logic signed [vtyp_pkg::DATA_W-1:0] y_in,
   input  logic signed [vtyp_pkg::ANG_W-1:0]  z_in,
   input  logic [SIDE_W-1:0]                 side_in,
   output logic                              out_valid,
   output logic signed [vtyp_pkg::DATA_W-1:0] x_out,
   output logic signed [vtyp_pkg::DATA_W-1:0] y_out,
   output logic signed [vtyp_pkg::ANG_W-1:0]  z_out,
   output logic [SIDE_W-1:0]                 side_out
);
   import vtyp_pkg::*;

   logic                     valid_ff;
   logic signed [DATA_W-1:0] x_ff, y_ff, x_in_nx, y_in_nx;
   logic signed [ANG_W-1:0]  z_ff, z_in_nx;
   logic [SIDE_W-1:0]        side_ff;
   logic signed [DATA_W-1:0] xs, ys;

   always_comb begin
      xs = x_in >>> IDX;
      ys = y_in >>> IDX;
      if (!y_in[DATA_W-1]) begin
         x_in_nx = x_in + ys;
         y_in_nx = y_in - xs;
         z_in_nx = z_in + atan_entry(IDX);
      end else begin
         x_in_nx = x_in - ys;
         y_in_nx = y_in + xs;
         z_in_nx = z_in - atan_entry(IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= x_in_nx;
         y_ff    <= y_in_nx;
         z_ff    <= z_in_nx;
         side_ff <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign z_out     = z_ff;
   assign side_out  = side_ff;

endmodule

FILE: rtl/vtyp_gain.sv
// Two-stage CORDIC gain correction: multiply split at bit 30, then sum.
// Depends on vtyp_pkg.
module vtyp_gain #(
   parameter int SIDE_W = 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic                               in_valid,
   input  logic signed [vtyp_pkg::DATA_W-1:0] x_in,
   input  logic [SIDE_W-1:0]                  side_in,
   output logic                               out_valid,
   output logic signed [vtyp_pkg::DATA_W-1:0] r_out,
   output logic [SIDE_W-1:0]                  side_out
);
   import vtyp_pkg::*;

   logic                    valid_a_ff, valid_b_ff;
   logic [61:0]             hi_ff;
   logic [59:0]             lo_ff;
   logic [SIDE_W-1:0]       side_a_ff, side_b_ff;
   logic [DATA_W-1:0]       r_ff, r_in;

   // x is non-negative and below 2^62 after vectoring
   assign r_in = DATA_W'(hi_ff) + DATA_W'(lo_ff[59:GAIN_W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else if (advance) begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hi_ff     <= x_in[61:GAIN_W] * INV_GAIN;
         lo_ff     <= x_in[GAIN_W-1:0] * INV_GAIN;
         side_a_ff <= side_in;
         r_ff      <= r_in;
         side_b_ff <= side_a_ff;
      end
   end

   assign out_valid = valid_b_ff;
   assign r_out     = signed'(r_ff);
   assign side_out  = side_b_ff;

endmodule

FILE: rtl/vector_to_yaw_pitch.sv
// Direction finder top level: observer position in, yaw and pitch toward the target out.
// Depends on vtyp_pkg, vtyp_stage and vtyp_gain.
//
// One item is accepted every clock cycle while the result register is free or being
// taken; each passes 2*CORDIC_STAGES + 5 register stages: the delta and pre-rotation
// stages at the front, the two CORDIC vectoring chains (one stage per micro-rotation),
// the two-stage gain multiply between them and the output register. The whole pipeline
// advances together whenever the result register is empty or being taken, so rsp_stall
// reaches req_stall directly.
// Targets and yaw_offset are read live and must only change while the block is idle.
module vector_to_yaw_pitch #(
   parameter int COORD_BITS    = vtyp_pkg::COORD_BITS_DEF,
   parameter int CORDIC_STAGES = vtyp_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [COORD_BITS-1:0]          req_observer_x,
   input  logic signed [COORD_BITS-1:0]          req_observer_y,
   input  logic signed [COORD_BITS-1:0]          req_observer_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [vtyp_pkg::OUT_YAW_W-1:0] rsp_yaw_angle,
   output logic signed [vtyp_pkg::PITCH_W-1:0]   rsp_pitch_angle,
   output logic                                  rsp_coincident,
   input  logic                                  csr_wen,
   input  logic [vtyp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [((COORD_BITS > vtyp_pkg::OFS_W) ? COORD_BITS : vtyp_pkg::OFS_W)-1:0]
                                                 csr_wdata
);
   import vtyp_pkg::*;

   localparam int DW       = COORD_BITS + 1;
   localparam int PRESHIFT = 60 - COORD_BITS;
   localparam int N        = CORDIC_STAGES;
   localparam int SIDE_Y_W = DW + 2;
   localparam int SIDE_G_W = YAW_W + DW + 1;
   localparam int SIDE_P_W = YAW_W + 1;

   // Configuration registers
   logic signed [COORD_BITS-1:0] tgt_x_ff, tgt_y_ff, tgt_z_ff;
   logic signed [OFS_W-1:0]      yaw_ofs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_x_ff   <= RST_TARGET_X[COORD_BITS-1:0];
         tgt_y_ff   <= RST_TARGET_Y[COORD_BITS-1:0];
         tgt_z_ff   <= RST_TARGET_Z[COORD_BITS-1:0];
         yaw_ofs_ff <= RST_YAW_OFFSET;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_TARGET_X:   tgt_x_ff   <= csr_wdata[COORD_BITS-1:0];
            CSR_TARGET_Y:   tgt_y_ff   <= csr_wdata[COORD_BITS-1:0];
            CSR_TARGET_Z:   tgt_z_ff   <= csr_wdata[COORD_BITS-1:0];
            CSR_YAW_OFFSET: yaw_ofs_ff <= csr_wdata[OFS_W-1:0];
            default:        ;
         endcase
      end
   end

   // Global advance: move every stage when the result register is free or being taken
   logic advance;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // Stage 0: deltas
   logic                 s0_valid_ff;
   logic signed [DW-1:0] dx_ff, dy_ff, dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff <= DW'(tgt_x_ff) - DW'(req_observer_x);
         dy_ff <= DW'(tgt_y_ff) - DW'(req_observer_y);
         dz_ff <= DW'(tgt_z_ff) - DW'(req_observer_z);
      end
   end

   // Stage 1: scale and fold the left half plane onto the right by +-90 degrees
   logic signed [DATA_W-1:0] xs, ys, x1_in, y1_in, x1_ff, y1_ff;
   logic signed [ANG_W-1:0]  z1_in, z1_ff;
   logic                     s1_valid_ff;
   logic [SIDE_Y_W-1:0]      side1_ff;
   flags_type                flags_in;

   always_comb begin
      xs = DATA_W'(dx_ff) <<< PRESHIFT;
      ys = DATA_W'(dy_ff) <<< PRESHIFT;
      x1_in = xs;
      y1_in = ys;
      z1_in = '0;
      if (dx_ff[DW-1]) begin
         if (!dy_ff[DW-1]) begin
            x1_in = ys;
            y1_in = -xs;
            z1_in = DEG90;
         end else begin
            x1_in = -ys;
            y1_in = xs;
            z1_in = -DEG90;
         end
      end
      flags_in.horiz_zero = (dx_ff == '0) && (dy_ff == '0);
      flags_in.coincident = flags_in.horiz_zero && (dz_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x1_ff    <= x1_in;
         y1_ff    <= y1_in;
         z1_ff    <= z1_in;
         side1_ff <= {dz_ff, flags_in};
      end
   end

   // Yaw vectoring chain
   logic                     yv [0:N];
   logic signed [DATA_W-1:0] yx [0:N];
   logic signed [DATA_W-1:0] yy [0:N];
   logic signed [ANG_W-1:0]  yz [0:N];
   logic [SIDE_Y_W-1:0]      yside [0:N];

   assign yv[0]    = s1_valid_ff;
   assign yx[0]    = x1_ff;
   assign yy[0]    = y1_ff;
   assign yz[0]    = z1_ff;
   assign yside[0] = side1_ff;

   for (genvar i = 0; i < N; i++) begin : g_yaw
      vtyp_stage #(.IDX(i), .SIDE_W(SIDE_Y_W)) u_stage (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_valid (yv[i]),
         .x_in     (yx[i]),
         .y_in     (yy[i]),
         .z_in     (yz[i]),
         .side_in  (yside[i]),
         .out_valid(yv[i+1]),
         .x_out    (yx[i+1]),
         .y_out    (yy[i+1]),
         .z_out    (yz[i+1]),
         .side_out (yside[i+1])
      );
   end

   // Round the yaw; a vertical line has no horizontal direction: yaw and magnitude are zero
   flags_type                yflags;
   logic signed [DW-1:0]     ydz;
   logic signed [YAW_W-1:0]  yaw_raw;
   logic signed [DATA_W-1:0] gx_in;
   logic signed [ANG_W-1:0]  yaw_fin;

   always_comb begin
      {ydz, yflags} = yside[N];
      yaw_fin = finish_angle(yz[N], YAW_LIMIT);
      yaw_raw = yflags.horiz_zero ? '0 : yaw_fin[YAW_W-1:0];
      gx_in   = yflags.horiz_zero ? '0 : yx[N];
   end

   logic                     gv;
   logic signed [DATA_W-1:0] gr;
   logic [SIDE_G_W-1:0]      gside;

   vtyp_gain #(.SIDE_W(SIDE_G_W)) u_gain (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (yv[N]),
      .x_in     (gx_in),
      .side_in  ({yaw_raw, ydz, yflags.coincident}),
      .out_valid(gv),
      .r_out    (gr),
      .side_out (gside)
   );

   // Pitch vectoring chain on (horizontal magnitude, scaled dz)
   logic                     pv [0:N];
   logic signed [DATA_W-1:0] px [0:N];
   logic signed [DATA_W-1:0] py [0:N];
   logic signed [ANG_W-1:0]  pz [0:N];
   logic [SIDE_P_W-1:0]      pside [0:N];
   logic signed [DW-1:0]     gdz;

   assign gdz      = gside[DW:1];
   assign pv[0]    = gv;
   assign px[0]    = gr;
   assign py[0]    = DATA_W'(gdz) <<< PRESHIFT;
   assign pz[0]    = '0;
   assign pside[0] = {gside[SIDE_G_W-1 -: YAW_W], gside[0]};

   for (genvar i = 0; i < N; i++) begin : g_pitch
      vtyp_stage #(.IDX(i), .SIDE_W(SIDE_P_W)) u_stage (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_valid (pv[i]),
         .x_in     (px[i]),
         .y_in     (py[i]),
         .z_in     (pz[i]),
         .side_in  (pside[i]),
         .out_valid(pv[i+1]),
         .x_out    (px[i+1]),
         .y_out    (py[i+1]),
         .z_out    (pz[i+1]),
         .side_out (pside[i+1])
      );
   end

   // Output register: round pitch, add the yaw offset, zero both when coincident
   logic                       out_valid_ff;
   logic signed [OUT_YAW_W-1:0] yaw_out_ff, yaw_out_in;
   logic signed [PITCH_W-1:0]  pitch_out_ff, pitch_out_in;
   logic                       coin_out_ff;
   logic signed [ANG_W-1:0]    pitch_fin;
   logic signed [YAW_W-1:0]    p_yaw;
   logic                       p_coin;

   always_comb begin
      {p_yaw, p_coin} = pside[N];
      pitch_fin    = finish_angle(pz[N], PITCH_LIMIT);
      pitch_out_in = p_coin ? '0 : pitch_fin[PITCH_W-1:0];
      yaw_out_in   = p_coin ? '0 : (OUT_YAW_W'(p_yaw) + OUT_YAW_W'(yaw_ofs_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= pv[N];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         yaw_out_ff   <= yaw_out_in;
         pitch_out_ff <= pitch_out_in;
         coin_out_ff  <= p_coin;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_yaw_angle   = yaw_out_ff;
   assign rsp_pitch_angle = pitch_out_ff;
   assign rsp_coincident  = coin_out_ff;

   // A coincident item carries zero angles
   a_coin_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_coincident) |-> (rsp_yaw_angle == '0 && rsp_pitch_angle == '0))
      else $error("coincident item with nonzero angle");

   // Pitch stays within +-90 degrees
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle <= 14'sd5760 && rsp_pitch_angle >= -14'sd5760))
      else $error("pitch out of range");

   // A held result freezes the whole pipeline
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(s0_valid_ff) && $stable(yv[N]) && $stable(gv)))
      else $error("pipeline moved under stall");

endmodule

FILE: sim/vtyp_checker.sv
// Checker for the direction finder: predicts yaw, pitch and coincidence for each item.
// Depends on vtyp_pkg; watches the request, response and register ports of the block.
module vtyp_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic signed [23:0]                    req_observer_x,
   input  logic signed [23:0]                    req_observer_y,
   input  logic signed [23:0]                    req_observer_z,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic signed [vtyp_pkg::OUT_YAW_W-1:0] rsp_yaw_angle,
   input  logic signed [vtyp_pkg::PITCH_W-1:0]   rsp_pitch_angle,
   input  logic                                  rsp_coincident,
   input  logic                                  csr_wen,
   input  logic [vtyp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [23:0]                           csr_wdata,
   output int                                    fail_count,
   output int                                    pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import vtyp_pkg::*;

   typedef struct packed {
      logic signed [16:0] yaw;
      logic signed [13:0] pitch;
      logic               coin;
   } direction_type;

   localparam int TAB_LEN = 16;
   localparam longint ATAN_TAB [TAB_LEN] = '{737280, 435242, 229970, 116736, 58595,
      29326, 14667, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};

   logic signed [23:0] tgt_x, tgt_y, tgt_z;
   logic signed [15:0] yaw_ofs;
   direction_type expected_dirs[$];

   function automatic longint rotate_to_axis(inout longint x, inout longint y, input longint z);
      longint xs, ys;
      for (int i = 0; i < TAB_LEN; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += ATAN_TAB[i];
         end else begin
            x -= ys; y += xs; z -= ATAN_TAB[i];
         end
      end
      return z;
   endfunction

   function automatic longint round_clamp(input longint z, input longint lim);
      longint r;
      r = (z + 128) >>> 8;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic direction_type aim_at_target(input logic signed [23:0] ox,
      input logic signed [23:0] oy, input logic signed [23:0] oz);
      direction_type d;
      longint dx, dy, dz, x, y, z, t, yaw, r;
      logic [63:0] ux;
      dx = longint'(tgt_x) - longint'(ox);
      dy = longint'(tgt_y) - longint'(oy);
      dz = longint'(tgt_z) - longint'(oz);
      yaw = 0;
      r = 0;
      if (dx == 0 && dy == 0 && dz == 0) begin
         d.yaw = '0; d.pitch = '0; d.coin = 1'b1;
         return d;
      end
      if (!(dx == 0 && dy == 0)) begin
         x = dx <<< 36;
         y = dy <<< 36;
         z = 0;
         // fold the left half plane onto the right one first
         if (x < 0) begin
            t = x;
            if (y >= 0) begin
               x = y; y = -t; z = 1474560;
            end else begin
               x = -y; y = t; z = -1474560;
            end
         end
         z = rotate_to_axis(x, y, z);
         yaw = round_clamp(z, 11520);
         ux = x;
         r = longint'((ux >> 30) * 64'd652032874 + (((ux & 64'h3FFF_FFFF) * 64'd652032874) >> 30));
      end
      y = dz <<< 36;
      z = rotate_to_axis(r, y, 0);
      d.pitch = 14'(round_clamp(z, 5760));
      d.yaw = 17'(yaw + longint'(yaw_ofs));
      d.coin = 1'b0;
      return d;
   endfunction

   assign pending = expected_dirs.size();

   always @(posedge clock) begin
      direction_type got, exp_d;
      if (reset) begin
         tgt_x <= 24'sd14080;
         tgt_y <= 24'sd17152;
         tgt_z <= 24'sd2560;
         yaw_ofs <= 16'sd5760;
         fail_count <= 0;
         expected_dirs.delete();
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_TARGET_X:   tgt_x <= csr_wdata;
               CSR_TARGET_Y:   tgt_y <= csr_wdata;
               CSR_TARGET_Z:   tgt_z <= csr_wdata;
               CSR_YAW_OFFSET: yaw_ofs <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_dirs.push_back(aim_at_target(req_observer_x, req_observer_y,
                                                  req_observer_z));
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_yaw_angle, rsp_pitch_angle, rsp_coincident};
            if (expected_dirs.size() == 0) begin
               $error("result with no item outstanding");
               fail_count <= fail_count + 1;
            end else begin
               exp_d = expected_dirs.pop_front();
               if (got.yaw !== exp_d.yaw)
                  $error("yaw_angle expected %0d got %0d", exp_d.yaw, got.yaw);
               if (got.pitch !== exp_d.pitch)
                  $error("pitch_angle expected %0d got %0d", exp_d.pitch, got.pitch);
               if (got.coin !== exp_d.coin)
                  $error("coincident expected %0d got %0d", exp_d.coin, got.coin);
               if (got !== exp_d) fail_count <= fail_count + 1;
            end
         end
      end
   end
endmodule

FILE: sim/tb.sv
// Top of the direction finder testbench: clock, reset, register writes and observer items.
// Depends on vtyp_pkg, vtyp_checker and the vector_to_yaw_pitch block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import vtyp_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [23:0] req_observer_x = '0, req_observer_y = '0, req_observer_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [16:0] rsp_yaw_angle;
   logic signed [13:0] rsp_pitch_angle;
   logic rsp_coincident;
   logic csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_TARGET_X;
   logic [23:0] csr_wdata = '0;
   int fail_count, pending;
   int send_idle_pct = 0, recv_stall_pct = 0;
   logic signed [23:0] cur_tx = 24'sd14080, cur_ty = 24'sd17152, cur_tz = 24'sd2560;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   vector_to_yaw_pitch DUT (.*);

   vtyp_checker checker_i (.*);

   // receiver: stall at random, re-decided every falling edge
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   // drive one item, holding it until accepted
   task automatic send_item(input logic signed [23:0] ox, oy, oz);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_observer_x <= ox;
      req_observer_y <= oy;
      req_observer_z <= oz;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (45) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [23:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_wen <= 1'b1;
      @(negedge clock);
      csr_wen <= 1'b0;
      case (idx)
         CSR_TARGET_X: cur_tx = val;
         CSR_TARGET_Y: cur_ty = val;
         CSR_TARGET_Z: cur_tz = val;
         default: ;
      endcase
   endtask

   // random observer: mostly near the target, sometimes anywhere, sometimes on it
   task automatic send_random();
      int kind;
      logic signed [23:0] ox, oy, oz;
      kind = $urandom_range(99);
      ox = 24'($urandom); oy = 24'($urandom); oz = 24'($urandom);
      if (kind < 10) begin
         ox = cur_tx; oy = cur_ty; oz = cur_tz;
         if (kind < 4) oz = 24'($urandom);
         else if (kind < 6) oy = cur_ty;
      end else if (kind < 60) begin
         ox = cur_tx + 24'($signed($urandom_range(8191)) - 4096);
         oy = cur_ty + 24'($signed($urandom_range(8191)) - 4096);
         oz = cur_tz + 24'($signed($urandom_range(8191)) - 4096);
         if (kind < 20) oy = cur_ty;
      end
      send_item(ox, oy, oz);
   endtask

   initial begin
      logic signed [23:0] mx, mn;
      mx = 24'sh7FFFFF;
      mn = -24'sh800000;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset target, then the edge cases
      send_item(24'sd14080, 24'sd17152, 24'sd2560);   // on the target
      send_item(24'sd14080, 24'sd17152, 24'sd0);      // straight above
      send_item(24'sd14080, 24'sd17152, mx);          // straight below
      send_item(24'sd20000, 24'sd17152, 24'sd2560);   // negative x axis
      send_item(24'sd20000, 24'sd10000, 24'sd2560);
      send_item(24'sd20000, 24'sd20000, 24'sd2560);
      send_item(24'sd0, 24'sd0, 24'sd0);
      send_item(mx, mx, mx);
      send_item(mn, mn, mn);
      send_item(mx, mn, mx);
      send_item(mn, mx, mn);
      drain();

      // extreme targets and offsets, including outside the nominal range
      write_reg(CSR_TARGET_X, 24'h7FFFFF);
      write_reg(CSR_TARGET_Y, 24'h800000);
      write_reg(CSR_TARGET_Z, 24'h7FFFFF);
      write_reg(CSR_YAW_OFFSET, 24'h007FFF);
      send_item(mn, mx, mn);
      send_item(mx, mn, mx);
      send_item(mn, mn, mx);
      send_item(24'sd0, 24'sd0, 24'sd0);
      send_item(mx, mx, mn);
      drain();
      write_reg(CSR_TARGET_X, 24'h800000);
      write_reg(CSR_TARGET_Y, 24'h7FFFFF);
      write_reg(CSR_TARGET_Z, 24'h800000);
      write_reg(CSR_YAW_OFFSET, 24'h008000);
      send_item(mx, mn, mx);
      send_item(mn, mx, mn);
      send_item(mx, mx, mx);
      send_item(mn, mn, mn);
      drain();

      // random phases: receiver stalls often, then sender idles often, then neither
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 50 : 0;
         recv_stall_pct = (ph == 0) ? 50 : (ph == 1) ? 9 : 0;
         write_reg(CSR_TARGET_X, 24'($urandom));
         write_reg(CSR_TARGET_Y, 24'($urandom));
         write_reg(CSR_TARGET_Z, 24'($urandom));
         write_reg(CSR_YAW_OFFSET, 24'($signed($urandom_range(46080)) - 23040));
         for (int n = 0; n < 280; n++) begin
            send_random();
            // hold off until everything outstanding has come back
            if (n == 140) drain();
         end
         drain();
      end

      if (fail_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #2ms;
      $display("Some tests failed");
      $finish;
   end
endmodule

FILE: sim.f
rtl/vtyp_pkg.sv
rtl/vtyp_stage.sv
rtl/vtyp_gain.sv
rtl/vector_to_yaw_pitch.sv
sim/vtyp_checker.sv
sim/tb.sv
